### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check that is switched off while reset is asserted.
`define DG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// Clocked check that also holds through reset.
`define DG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`else

`define DG_ASSERT(lbl, clk, rstn, prop)
`define DG_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### rtl/core/dgpio_pkg.sv
package dgpio_pkg;

    localparam int DATA_W            = 32;
    localparam int CNT_W             = 6;
    localparam int PIN_WIDTH_DEFAULT = 32;
    localparam int PIN_WIDTH_MAX     = 32;

    localparam int ACT_W  = 2;
    localparam int IDX_W  = 4;
    localparam int CFG_IDX_W = 1;

    // Stream packing.
    localparam int S_TUSER_W = ACT_W + IDX_W;
    localparam int S_TDATA_W = 5 * DATA_W;
    localparam int M_TDATA_W = ((2 * DATA_W + 1 + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - 2 * DATA_W - 1;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(32);

    // Access kinds.
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd2;

    // Register map, word indexes.
    localparam logic [IDX_W-1:0] REG_CFG      = 4'd0;
    localparam logic [IDX_W-1:0] REG_OUT      = 4'd1;
    localparam logic [IDX_W-1:0] REG_OUTFAULT = 4'd2;
    localparam logic [IDX_W-1:0] REG_LOOP     = 4'd3;
    localparam logic [IDX_W-1:0] REG_IN       = 4'd4;
    localparam logic [IDX_W-1:0] REG_RISE     = 4'd5;
    localparam logic [IDX_W-1:0] REG_FALL     = 4'd6;
    localparam logic [IDX_W-1:0] REG_STATUS   = 4'd7;
    localparam logic [IDX_W-1:0] REG_INFAULT  = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 1'b1;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] pin_levels;
        logic [DATA_W-1:0] loopback_levels;
        logic [DATA_W-1:0] output_faults;
        logic [DATA_W-1:0] input_faults;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [DATA_W-1:0] drive_levels;
        logic              irq;
        logic              bad_address;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0] input_pin_count;
        logic [CNT_W-1:0] output_pin_count;
    } pin_counts_t;

endpackage

### rtl/core/dgpio_in_stage.sv
module dgpio_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  dgpio_pkg::item_t in_item,
    output logic            item_valid,
    output dgpio_pkg::item_t item,
    input  logic            advance
);
    import dgpio_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // The stage can refill in the same cycle its beat moves on.
    assign in_ready = !valid_reg || advance;
    assign load     = in_valid && in_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/core/dgpio_core.sv
`include "assert_macros.svh"

module dgpio_core #(
    parameter int PIN_WIDTH = dgpio_pkg::PIN_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_valid,
    input  dgpio_pkg::item_t       item,
    output logic                   advance,
    input  dgpio_pkg::pin_counts_t counts,
    output logic                   out_valid,
    input  logic                   out_ready,
    output dgpio_pkg::result_t     result
);
    import dgpio_pkg::*;

    logic [PIN_WIDTH-1:0] latch_reg,  latch_next;
    logic [PIN_WIDTH-1:0] rise_reg,   rise_next;
    logic [PIN_WIDTH-1:0] fall_reg,   fall_next;
    logic [PIN_WIDTH-1:0] status_reg, status_next;
    logic [PIN_WIDTH-1:0] prev_reg;

    logic [PIN_WIDTH-1:0] imask, omask;
    logic [PIN_WIDTH-1:0] data, pins, loop, ofault, ifault;
    logic [PIN_WIDTH-1:0] clear_bits, rise_edges, fall_edges;
    logic                 is_access, bad, wr_en, rd_en;
    logic [DATA_W-1:0]    rd_word;

    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;

    // An item moves through when the result register is free or being drained.
    assign advance = item_valid && (!out_valid_reg || out_ready);

    assign data   = item.write_data[PIN_WIDTH-1:0];
    assign pins   = item.pin_levels[PIN_WIDTH-1:0];
    assign loop   = item.loopback_levels[PIN_WIDTH-1:0];
    assign ofault = item.output_faults[PIN_WIDTH-1:0];
    assign ifault = item.input_faults[PIN_WIDTH-1:0];

    // Pin masks: the low count bits set, capped at the pin width.
    always_comb begin
        for (int i = 0; i < PIN_WIDTH; i++) begin
            imask[i] = CNT_W'(i) < counts.input_pin_count;
            omask[i] = CNT_W'(i) < counts.output_pin_count;
        end
    end

    assign is_access = (item.action == ACT_READ) || (item.action == ACT_WRITE);
    assign bad       = is_access && (item.reg_index > REG_INFAULT);
    assign wr_en     = (item.action == ACT_WRITE) && !bad;
    assign rd_en     = (item.action == ACT_READ) && !bad;

    // Reads see the registers as they stood before this item's update.
    always_comb begin
        unique case (item.reg_index)
            REG_CFG: begin
                rd_word = DATA_W'({counts.output_pin_count, 2'b00,
                                   counts.input_pin_count});
            end
            REG_OUT:      rd_word = DATA_W'(latch_reg);
            REG_OUTFAULT: rd_word = DATA_W'(ofault);
            REG_LOOP:     rd_word = DATA_W'(loop);
            REG_IN:       rd_word = DATA_W'(pins);
            REG_RISE:     rd_word = DATA_W'(rise_reg);
            REG_FALL:     rd_word = DATA_W'(fall_reg);
            REG_STATUS:   rd_word = DATA_W'(status_reg);
            REG_INFAULT:  rd_word = DATA_W'(ifault);
            default:      rd_word = '0;
        endcase
    end

    always_comb begin
        latch_next = latch_reg;
        rise_next  = rise_reg;
        fall_next  = fall_reg;
        clear_bits = '0;
        if (wr_en) begin
            if (item.reg_index == REG_OUT) begin
                latch_next = data & omask;
            end
            if (item.reg_index == REG_RISE) begin
                rise_next = data;
            end
            if (item.reg_index == REG_FALL) begin
                fall_next = data;
            end
            if (item.reg_index == REG_STATUS) begin
                clear_bits = data;
            end
        end
        // Edges use the enables as written by this same item, and a new edge
        // wins over a clear of the same bit.
        rise_edges  = pins & ~prev_reg;
        fall_edges  = ~pins & prev_reg;
        status_next = (status_reg & ~clear_bits)
                    | (((rise_edges & rise_next) | (fall_edges & fall_next)) & imask);
    end

    always_comb begin
        out_next.read_data    = rd_en ? rd_word : '0;
        out_next.drive_levels = DATA_W'(latch_next);
        out_next.irq          = |status_next;
        out_next.bad_address  = bad;

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg     <= '0;
            rise_reg      <= '0;
            fall_reg      <= '0;
            status_reg    <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                latch_reg  <= latch_next;
                rise_reg   <= rise_next;
                fall_reg   <= fall_next;
                status_reg <= status_next;
                prev_reg   <= pins;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    `DG_ASSERT(a_irq_tracks_status, aclk, aresetn, out_valid_reg |-> (out_reg.irq == (status_reg != '0)))
    `DG_ASSERT(a_drive_tracks_latch, aclk, aresetn, out_valid_reg |-> (out_reg.drive_levels == DATA_W'(latch_reg)))
    `DG_ASSERT(a_bad_reads_zero, aclk, aresetn, (out_valid_reg && out_reg.bad_address) |-> (out_reg.read_data == '0))
    `DG_ASSERT(a_state_holds, aclk, aresetn, !advance |=> ($stable(status_reg) && $stable(latch_reg)))
    `DG_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !out_valid_reg)

endmodule

### rtl/core/discrete_gpio_edge_irq.sv
// An accepted beat is registered in the input stage, then in the result register.
// Throughput: one beat per cycle; an input register and a result register
// carry the stream, and both stages move together whenever the result is taken.
// Reset: aresetn is synchronous and active low; it empties both stages, clears
// the output latch, the edge enables, the status and the previous sample, and
// sets both pin counts to 32.
module discrete_gpio_edge_irq #(
    parameter int PIN_WIDTH = dgpio_pkg::PIN_WIDTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Input stream, one beat per ready clock, of pin samples and an optional access.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // From bit 0: write_data, pin_levels, loopback_levels, output_faults,
    // input_faults, 32 bits each.
    input  logic [dgpio_pkg::S_TDATA_W-1:0]   s_tdata,
    // From bit 0: action (2 bits), reg_index (4 bits).
    input  logic [dgpio_pkg::S_TUSER_W-1:0]   s_tuser,

    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // From bit 0: read_data (32), drive_levels (32), irq (1), zero padding.
    output logic [dgpio_pkg::M_TDATA_W-1:0]   m_tdata,
    // Bit 0: bad_address.
    output logic                              m_tuser,

    // Configuration writes; only issued while the block is idle.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dgpio_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dgpio_pkg::CNT_W-1:0]       cfg_data
);
    import dgpio_pkg::*;

    item_t       in_item;
    item_t       item;
    logic        item_valid;
    logic        advance;
    result_t     result;
    pin_counts_t counts_reg;
    pin_counts_t counts_next;

    // Unpack the input beat into the item fields.
    assign in_item.action          = s_tuser[ACT_W-1:0];
    assign in_item.reg_index       = s_tuser[ACT_W+IDX_W-1:ACT_W];
    assign in_item.write_data      = s_tdata[DATA_W-1:0];
    assign in_item.pin_levels      = s_tdata[2*DATA_W-1:DATA_W];
    assign in_item.loopback_levels = s_tdata[3*DATA_W-1:2*DATA_W];
    assign in_item.output_faults   = s_tdata[4*DATA_W-1:3*DATA_W];
    assign in_item.input_faults    = s_tdata[5*DATA_W-1:4*DATA_W];

    // The pin counts are plain registers; a write is always taken at once.
    assign cfg_ready = 1'b1;

    always_comb begin
        counts_next = counts_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_INPUT_COUNT:  counts_next.input_pin_count  = cfg_data;
                CFG_OUTPUT_COUNT: counts_next.output_pin_count = cfg_data;
                default:          counts_next = counts_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counts_reg.input_pin_count  <= COUNT_RESET;
            counts_reg.output_pin_count <= COUNT_RESET;
        end else begin
            counts_reg <= counts_next;
        end
    end

    // First stage: registers the accepted beat.
    dgpio_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance)
    );

    // Second stage: register file, edge detection and the result register.
    dgpio_core #(
        .PIN_WIDTH (PIN_WIDTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .counts     (counts_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result     (result)
    );

    // Pack the result beat.
    assign m_tdata = {{M_PAD_W{1'b0}}, result.irq, result.drive_levels, result.read_data};
    assign m_tuser = result.bad_address;

endmodule

### dv/discrete_gpio_edge_irq_checker.sv
`timescale 1ns / 100ps

module discrete_gpio_edge_irq_checker #(
    parameter int PIN_WIDTH = dgpio_pkg::PIN_WIDTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [dgpio_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [dgpio_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [dgpio_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                            m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [dgpio_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dgpio_pkg::CNT_W-1:0]     cfg_data,
    output int                              mismatch_count,
    output int                              results_pending
);
    import dgpio_pkg::*;

    // Shadow copy of the peripheral's registers.
    logic [CNT_W-1:0]  in_count;
    logic [CNT_W-1:0]  out_count;
    logic [DATA_W-1:0] out_latch;
    logic [DATA_W-1:0] rise_en;
    logic [DATA_W-1:0] fall_en;
    logic [DATA_W-1:0] edge_status;
    logic [DATA_W-1:0] last_pins;

    result_t bus_replies_q[$];
    int      mismatches = 0;

    function automatic logic [DATA_W-1:0] low_mask(input int unsigned n);
        int unsigned k;
        k = (n > PIN_WIDTH) ? PIN_WIDTH : n;
        if (k >= DATA_W) return '1;
        return ~({DATA_W{1'b1}} << k);
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatches++;
        $display("%0t gpio check: %s got %h want %h", $time, what, got, want);
    endtask

    // One beat of the peripheral: the bus access, then edge capture.
    task automatic advance_gpio(input item_t beat, output result_t reply);
        logic [DATA_W-1:0] wmask, imask, omask;
        logic [DATA_W-1:0] wdata, pins, rising, falling;
        wmask = low_mask(DATA_W);
        imask = low_mask(32'(in_count));
        omask = low_mask(32'(out_count));
        wdata = beat.write_data & wmask;
        pins  = beat.pin_levels & wmask;
        reply = '0;
        if (beat.action == ACT_READ || beat.action == ACT_WRITE) begin
            if (beat.reg_index > REG_INFAULT) begin
                reply.bad_address = 1'b1;
            end else if (beat.action == ACT_READ) begin
                case (beat.reg_index)
                    REG_CFG:      reply.read_data = {16'd0, 2'b00, out_count, 2'b00, in_count};
                    REG_OUT:      reply.read_data = out_latch;
                    REG_OUTFAULT: reply.read_data = beat.output_faults & wmask;
                    REG_LOOP:     reply.read_data = beat.loopback_levels & wmask;
                    REG_IN:       reply.read_data = pins;
                    REG_RISE:     reply.read_data = rise_en;
                    REG_FALL:     reply.read_data = fall_en;
                    REG_STATUS:   reply.read_data = edge_status;
                    REG_INFAULT:  reply.read_data = beat.input_faults & wmask;
                    default:      reply.read_data = '0;
                endcase
            end else begin
                case (beat.reg_index)
                    REG_OUT:    out_latch = wdata & omask;
                    REG_RISE:   rise_en = wdata;
                    REG_FALL:   fall_en = wdata;
                    REG_STATUS: edge_status = edge_status & ~wdata;
                    default:    ;
                endcase
            end
        end
        // Edges are latched after the clear, so a new edge survives it.
        rising  = pins & ~last_pins;
        falling = ~pins & last_pins;
        edge_status = (edge_status | (((rising & rise_en) | (falling & fall_en)) & imask))
                      & wmask;
        last_pins = pins;
        reply.drive_levels = out_latch;
        reply.irq = |edge_status;
    endtask

    always @(posedge aclk) begin : watch
        item_t   beat;
        result_t want;
        result_t got;
        if (!aresetn) begin
            in_count    = COUNT_RESET;
            out_count   = COUNT_RESET;
            out_latch   = '0;
            rise_en     = '0;
            fall_en     = '0;
            edge_status = '0;
            last_pins   = '0;
            bus_replies_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_INPUT_COUNT:  in_count = cfg_data;
                    CFG_OUTPUT_COUNT: out_count = cfg_data;
                    default:          ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                beat.action          = s_tuser[0 +: ACT_W];
                beat.reg_index       = s_tuser[ACT_W +: IDX_W];
                beat.write_data      = s_tdata[0 +: DATA_W];
                beat.pin_levels      = s_tdata[DATA_W +: DATA_W];
                beat.loopback_levels = s_tdata[2*DATA_W +: DATA_W];
                beat.output_faults   = s_tdata[3*DATA_W +: DATA_W];
                beat.input_faults    = s_tdata[4*DATA_W +: DATA_W];
                advance_gpio(beat, want);
                bus_replies_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.read_data    = m_tdata[0 +: DATA_W];
                got.drive_levels = m_tdata[DATA_W +: DATA_W];
                got.irq          = m_tdata[2*DATA_W];
                got.bad_address  = m_tuser;
                if (bus_replies_q.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding, read_data",
                                    got.read_data, '0);
                end else begin
                    want = bus_replies_q.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", got.read_data, want.read_data);
                    if (got.drive_levels !== want.drive_levels)
                        report_mismatch("drive_levels", got.drive_levels, want.drive_levels);
                    if (got.irq !== want.irq)
                        report_mismatch("irq", DATA_W'(got.irq), DATA_W'(want.irq));
                    if (got.bad_address !== want.bad_address)
                        report_mismatch("bad_address", DATA_W'(got.bad_address),
                                        DATA_W'(want.bad_address));
                end
            end
        end
        mismatch_count  <= mismatches;
        results_pending <= bus_replies_q.size();
    end

endmodule

### dv/discrete_gpio_edge_irq_tb.sv
`timescale 1ns / 100ps

module discrete_gpio_edge_irq_tb;

    import dgpio_pkg::*;

    // Action code three is not a bus access; the block treats it as a plain
    // pin-sampling beat.
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    // Lowest and highest indexes past the end of the register map.
    localparam logic [IDX_W-1:0] REG_UNMAPPED_LO = 4'd9;
    localparam logic [IDX_W-1:0] REG_UNMAPPED_HI = 4'd15;

    // The receiver's long hold-off, in cycles. The block holds two beats, so
    // the input side stalls soon after the hold-off starts.
    localparam int HOLD_OFF_CYCLES = 80;

    // Longest stretch without any handshake in a correct run is the hold-off
    // plus a sender gap and the pass through both registers; the limit is far above it.
    localparam int WATCHDOG_LIMIT = 1000;

    localparam int PHASES          = 8;
    localparam int BEATS_PER_PHASE = 135;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_data  = '0;

    // Raised by the stimulus to ask the receiver for one long hold-off.
    logic hold_off_req = 1'b0;

    int mismatch_count;
    int results_pending;
    int quiet_cycles = 0;

    // Sender pacing: beats left in the current burst, and the pin levels last
    // offered, so that random pin words can be built as edges on top of them.
    int                burst_left = 0;
    logic [DATA_W-1:0] pin_state  = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    discrete_gpio_edge_irq i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    discrete_gpio_edge_irq_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // A beat with the given access and pin levels; the loopback and fault
    // words are random since they only matter when read back.
    function automatic item_t access(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                                     input logic [DATA_W-1:0] wdata,
                                     input logic [DATA_W-1:0] pins);
        item_t it;
        it.action          = act;
        it.reg_index       = idx;
        it.write_data      = wdata;
        it.pin_levels      = pins;
        it.loopback_levels = $urandom;
        it.output_faults   = $urandom;
        it.input_faults    = $urandom;
        return it;
    endfunction

    // Random traffic: mostly register accesses to mapped registers, some pure
    // sampling beats, now and then an unmapped index or the spare action code.
    // Pins mostly move by a few bits so that edges stay sparse and readable.
    function automatic item_t random_access(input logic [DATA_W-1:0] pins_now);
        logic [ACT_W-1:0]  act;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] wdata;
        logic [DATA_W-1:0] pins;
        case ($urandom_range(0, 9))
            0, 1:       act = ACT_NONE;
            2, 3, 4, 5: act = ACT_READ;
            6, 7, 8:    act = ACT_WRITE;
            default:    act = ACT_SPARE;
        endcase
        if ($urandom_range(0, 7) == 0)
            idx = IDX_W'($urandom_range(0, 15));
        else
            idx = IDX_W'($urandom_range(0, 8));
        case ($urandom_range(0, 3))
            0:       wdata = $urandom;
            1:       wdata = '1;
            2:       wdata = DATA_W'(1) << $urandom_range(0, 31);
            default: wdata = $urandom & $urandom;
        endcase
        case ($urandom_range(0, 3))
            0:       pins = pins_now;
            1:       pins = pins_now ^ ($urandom & $urandom & $urandom);
            2:       pins = pins_now ^ (DATA_W'(1) << $urandom_range(0, 31));
            default: pins = $urandom;
        endcase
        return access(act, idx, wdata, pins);
    endfunction

    // Offers one beat and returns at the edge where it is taken. Between
    // bursts the sender drops tvalid for a random gap; a zero gap joins two
    // bursts into one unbroken stretch.
    task automatic offer(input item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {it.input_faults, it.output_faults, it.loopback_levels,
                     it.pin_levels, it.write_data};
        s_tuser  <= {it.reg_index, it.action};
        pin_state = it.pin_levels;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stops offering and waits until every result beat has come back, then
    // lets the two-stage pipeline run empty a little longer.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes both pin counts back to back; cfg_valid stays high across the
    // two beats and drops after the second one.
    task automatic set_pin_counts(input logic [CNT_W-1:0] in_cnt,
                                  input logic [CNT_W-1:0] out_cnt);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_INPUT_COUNT;
        cfg_data  <= in_cnt;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= CFG_OUTPUT_COUNT;
        cfg_data  <= out_cnt;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver pacing. Each stretch picks one pattern: always ready, coin flips,
    // ready when the tick count is a multiple of three, or mostly ready. When
    // the stimulus asks for it, the receiver instead holds off for a long stretch
    // while the sender keeps offering, which backs the stall up into s_tready.
    initial begin : sink_pacing
        int  mode;
        int  stretch;
        int  tick;
        bit  hold_served;
        tick = 0;
        hold_served = 1'b0;
        forever begin
            if (hold_off_req && !hold_served) begin
                hold_served = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                if (!hold_off_req) hold_served = 1'b0;
                mode    = $urandom_range(0, 3);
                stretch = $urandom_range(8, 60);
                repeat (stretch) begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        2:       m_tready <= (tick % 3 == 0);
                        default: m_tready <= ($urandom_range(0, 7) != 0);
                    endcase
                    tick++;
                    @(posedge aclk);
                end
            end
        end
    end

    // Ends the run if no beat moves on any channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("discrete_gpio_edge_irq_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        item_t            it;
        logic [CNT_W-1:0] in_cnt;
        logic [CNT_W-1:0] out_cnt;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, with both pin counts at their reset value of 32.
        // The first beat has every pin high: a rising edge against the zero
        // reset sample, but no enable is set yet so nothing latches.
        offer(access(ACT_READ, REG_CFG, '0, '1));
        offer(access(ACT_WRITE, REG_RISE, '1, '1));
        // All pins fall with every fall enable set.
        offer(access(ACT_WRITE, REG_FALL, '1, '0));
        offer(access(ACT_READ, REG_STATUS, '0, '1));
        // Clearing every status bit while every pin falls again: the new edges
        // win, so status stays full; the repeat clear, with no new edge, empties it.
        offer(access(ACT_WRITE, REG_STATUS, '1, '0));
        offer(access(ACT_WRITE, REG_STATUS, '1, '0));
        offer(access(ACT_READ, REG_STATUS, '0, '0));
        offer(access(ACT_WRITE, REG_OUT, '1, '0));
        offer(access(ACT_READ, REG_OUT, '0, '0));

        // The sampled registers, each read once, with an all-ones or an all-zeros
        // word on its source.
        it = access(ACT_READ, REG_OUTFAULT, '0, '0);
        it.output_faults = '1;
        offer(it);
        it = access(ACT_READ, REG_LOOP, '1, '0);
        it.loopback_levels = '0;
        offer(it);
        offer(access(ACT_READ, REG_IN, '0, '1));
        it = access(ACT_READ, REG_INFAULT, '0, '1);
        it.input_faults = '0;
        offer(it);

        // Writes to read-only registers change nothing.
        offer(access(ACT_WRITE, REG_CFG, '1, '1));
        offer(access(ACT_WRITE, REG_OUTFAULT, '1, '1));
        offer(access(ACT_WRITE, REG_LOOP, '1, '1));
        offer(access(ACT_WRITE, REG_IN, '1, '1));
        offer(access(ACT_WRITE, REG_INFAULT, '1, '1));

        // Unmapped indexes flag bad_address and have no effect; the spare
        // action code with an unmapped index is only a sampling beat.
        offer(access(ACT_READ, REG_UNMAPPED_HI, '0, '1));
        offer(access(ACT_WRITE, REG_UNMAPPED_LO, '1, '1));
        offer(access(ACT_SPARE, REG_UNMAPPED_HI, '1, '1));
        offer(access(ACT_NONE, REG_STATUS, '1, '0));
        offer(access(ACT_WRITE, REG_STATUS, '1, '0));
        // Leave every status bit set, so that the first phase below sees bits
        // above a lowered input count still pending.
        offer(access(ACT_NONE, REG_CFG, '0, '1));

        // Random phases, each under its own pair of pin counts. The extremes
        // are 0 and 63; counts above 32 mask like 32 but read back as written.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       begin in_cnt = 6'd4;  out_cnt = 6'd5;  end
                1:       begin in_cnt = 6'd0;  out_cnt = 6'd0;  end
                2:       begin in_cnt = 6'd63; out_cnt = 6'd63; end
                3:       begin in_cnt = 6'd32; out_cnt = 6'd32; end
                4:       begin in_cnt = 6'd1;  out_cnt = 6'd31; end
                5:       begin in_cnt = 6'd33; out_cnt = 6'd0;  end
                default: begin
                    in_cnt  = CNT_W'($urandom_range(0, 63));
                    out_cnt = CNT_W'($urandom_range(0, 63));
                end
            endcase
            drain();
            set_pin_counts(in_cnt, out_cnt);
            if (phase == 2) hold_off_req <= 1'b1;
            offer(access(ACT_READ, REG_STATUS, '0, pin_state));
            offer(access(ACT_READ, REG_CFG, '0, pin_state));
            repeat (BEATS_PER_PHASE) offer(random_access(pin_state));
            if (phase == 2) hold_off_req <= 1'b0;
        end

        drain();
        if (mismatch_count == 0)
            $display("discrete_gpio_edge_irq_tb: PASS");
        else
            $display("discrete_gpio_edge_irq_tb: FAIL");
        $finish;
    end

endmodule

### discrete_gpio_edge_irq.f
+incdir+rtl/core
rtl/core/dgpio_pkg.sv
rtl/core/dgpio_in_stage.sv
rtl/core/dgpio_core.sv
rtl/core/discrete_gpio_edge_irq.sv
dv/discrete_gpio_edge_irq_checker.sv
dv/discrete_gpio_edge_irq_tb.sv
